// File: rtl/sft_pkg.sv
`default_nettype none
package sft_pkg;

    localparam int DEF_SOURCE_SLOTS     = 64;
    localparam int DEF_CONNS_PER_SOURCE = 16;
    localparam int DEF_TIME_BITS        = 48;

    localparam int APB_AW = 6;
    localparam int APB_DW = 64;

    localparam logic [2:0] REG_WINDOW   = 3'd0;
    localparam logic [2:0] REG_TIMEOUT  = 3'd1;
    localparam logic [2:0] REG_HO_LIMIT = 3'd2;
    localparam logic [2:0] REG_BURST    = 3'd3;
    localparam logic [2:0] REG_CAPACITY = 3'd4;

    localparam logic [47:0] RST_WINDOW   = 48'd1000000;
    localparam logic [46:0] RST_TIMEOUT  = 47'd5000000;
    localparam logic [4:0]  RST_HO_LIMIT = 5'd8;
    localparam logic [15:0] RST_BURST    = 16'd100;
    localparam logic [6:0]  RST_CAPACITY = 7'd64;

    localparam logic [1:0] OP_PACKET = 2'd0;
    localparam logic [1:0] OP_SWEEP  = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;

    localparam logic [1:0] FAM_V4 = 2'd1;
    localparam logic [1:0] FAM_V6 = 2'd2;

    localparam int         FLG_SYN        = 0;
    localparam int         FLG_ACK        = 1;
    localparam logic [3:0] FLG_CLOSE_MASK = 4'b1110;

    localparam logic [15:0] CNT_MAX = 16'hFFFF;

    typedef struct packed {
        logic [1:0]  operation;
        logic [47:0] time_us;
        logic        valid_tcp;
        logic [1:0]  addr_family;
        logic [63:0] src_addr_hi;
        logic [63:0] src_addr_lo;
        logic [63:0] dst_addr_hi;
        logic [63:0] dst_addr_lo;
        logic [15:0] src_port;
        logic [15:0] dst_port;
        logic [3:0]  tcp_flags;
    } t_in;

    typedef struct packed {
        logic        alert;
        logic [4:0]  half_open_count;
        logic [15:0] syn_count;
    } t_out;

endpackage
`default_nettype wire

// File: rtl/sft_ram.sv
`default_nettype none
module sft_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end

endmodule
`default_nettype wire

// File: rtl/syn_flood_tracker.sv
// channel  | handshake                      | payload
// ---------+--------------------------------+------------------------------
// item in  | start & !busy                  | i_item (sft_pkg::t_in)
// result   | o_done, one cycle, no stall    | o_result (sft_pkg::t_out)
// config   | psel & penable & pwrite        | paddr (8 bytes per reg), pwdata
//
// One item at a time; busy stays high until its result beat.
// Clear and ignored items go straight to the result beat. Packet closes scan
// the source memory (one read port) and, for a known source, the connection
// memory, once per direction; SYN items scan each memory once. Sweep visits
// every valid source slot and scans the connections of each one it keeps.
// Synchronous reset clears source valid bits and config; no clearing pass.
`default_nettype none
module syn_flood_tracker #(
    parameter int SOURCE_SLOTS     = sft_pkg::DEF_SOURCE_SLOTS,
    parameter int CONNS_PER_SOURCE = sft_pkg::DEF_CONNS_PER_SOURCE,
    parameter int TIME_BITS        = sft_pkg::DEF_TIME_BITS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    input  sft_pkg::t_in                i_item,
    output logic                        busy,
    output logic                        o_done,
    output sft_pkg::t_out               o_result,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [sft_pkg::APB_AW-1:0]  paddr,
    input  logic [sft_pkg::APB_DW-1:0]  pwdata,
    output logic [sft_pkg::APB_DW-1:0]  prdata,
    output logic                        pready
);
    import sft_pkg::*;

    localparam int SAW        = (SOURCE_SLOTS > 1) ? $clog2(SOURCE_SLOTS) : 1;
    localparam int SCW        = $clog2(SOURCE_SLOTS + 1);
    localparam int CAW        = (CONNS_PER_SOURCE > 1) ? $clog2(CONNS_PER_SOURCE) : 1;
    localparam int CCW        = $clog2(CONNS_PER_SOURCE + 1);
    localparam int CONN_TOTAL = SOURCE_SLOTS * CONNS_PER_SOURCE;
    localparam int TAW        = (CONN_TOTAL > 1) ? $clog2(CONN_TOTAL) : 1;
    localparam int HCW        = (CCW > 5) ? CCW : 5;
    localparam int CMW        = (SCW > 7) ? SCW : 7;

    typedef struct packed {
        logic [63:0]                 khi;
        logic [63:0]                 klo;
        logic [1:0]                  fam;
        logic [TIME_BITS-1:0]        ws;
        logic [TIME_BITS-1:0]        ls;
        logic [15:0]                 syn;
        logic [15:0]                 comp;
        logic                        alert;
        logic [CONNS_PER_SOURCE-1:0] mask;
    } t_src_rec;

    typedef struct packed {
        logic [63:0]          hi;
        logic [63:0]          lo;
        logic [1:0]           fam;
        logic [15:0]          lp;
        logic [15:0]          rp;
        logic [TIME_BITS-1:0] tm;
    } t_conn_rec;

    typedef enum logic [13:0] {
        S_IDLE  = 14'b00000000000001,
        S_SINIT = 14'b00000000000010,
        S_SSCAN = 14'b00000000000100,
        S_SRES  = 14'b00000000001000,
        S_SUPD  = 14'b00000000010000,
        S_CINIT = 14'b00000000100000,
        S_CSCAN = 14'b00000001000000,
        S_CLWR  = 14'b00000010000000,
        S_SYWR  = 14'b00000100000000,
        S_SWRD  = 14'b00001000000000,
        S_SWCHK = 14'b00010000000000,
        S_SWWR  = 14'b00100000000000,
        S_DONE  = 14'b01000000000000
    } t_state;

    typedef enum logic [3:0] {
        PH_CLOSE1 = 4'b0001,
        PH_CLOSE2 = 4'b0010,
        PH_SYN    = 4'b0100,
        PH_SWEEP  = 4'b1000
    } t_phase;

    function automatic logic f_aged(input logic [TIME_BITS-1:0] a_now,
                                    input logic [TIME_BITS-1:0] a_then,
                                    input logic [63:0] a_lim);
        return (a_now > a_then) && (64'(a_now - a_then) > a_lim);
    endfunction

    t_state r_state, n_state;
    t_phase r_phase, n_phase;
    logic [SOURCE_SLOTS-1:0] r_valid, n_valid;
    logic [47:0] r_wl;
    logic [46:0] r_hot;
    logic [4:0]  r_hol;
    logic [15:0] r_sbl;
    logic [6:0]  r_cap;

    logic [1:0]           r_fam, n_fam;
    logic [63:0]          r_shi, n_shi, r_slo, n_slo, r_dhi, n_dhi, r_dlo, n_dlo;
    logic [15:0]          r_sp, n_sp, r_dp, n_dp;
    logic [3:0]           r_fl, n_fl;
    logic [TIME_BITS-1:0] r_now, n_now;

    logic [SCW-1:0]       r_i, n_i, r_cnt, n_cnt, r_s, n_s;
    logic                 r_pv, n_pv, r_found, n_found, r_ffree, n_ffree, r_vfound, n_vfound;
    logic [SAW-1:0]       r_pi, n_pi, r_m, n_m, r_free, n_free, r_vic, n_vic;
    logic [TIME_BITS-1:0] r_vls, n_vls;
    t_src_rec             r_rec, n_rec;

    logic [CCW-1:0]       r_c, n_c, r_keep, n_keep;
    logic                 r_cpv, n_cpv, r_cfound, n_cfound, r_fifound, n_fifound;
    logic                 r_minf, n_minf;
    logic [CAW-1:0]       r_pc, n_pc, r_mc, n_mc, r_fi, n_fi, r_mi, n_mi;
    logic [TIME_BITS-1:0] r_mt, n_mt;
    logic [CONNS_PER_SOURCE-1:0] r_agem, n_agem;
    t_out                 r_res, n_res;

    logic                   src_we;
    logic [SAW-1:0]         src_waddr, src_raddr;
    logic [$bits(t_src_rec)-1:0]  src_wdata, src_rdata;
    logic                   conn_we;
    logic [TAW-1:0]         conn_waddr, conn_raddr, conn_base;
    logic [$bits(t_conn_rec)-1:0] conn_wdata, conn_rdata;
    t_src_rec               srec;
    t_conn_rec              crec;

    logic                 swap, has_syn, pkt_ok, evict, m_ok, win_reset, counted, alert_now;
    logic [63:0]          k_hi, k_lo, p_hi, p_lo;
    logic [15:0]          c_lp, c_rp;
    logic [CMW-1:0]       cap_min, cap_eff;
    logic [SAW-1:0]       free_i;
    logic [CAW-1:0]       slot;
    logic [CCW-1:0]       active;
    t_src_rec             upd_rec, clw_rec, syw_rec, sww_rec;
    t_state               adv_state;
    t_phase               adv_phase;
    logic                 cfg_wr;
    logic [63:0]          in_shi, in_slo, in_dhi, in_dlo;

    sft_ram #(.WIDTH($bits(t_src_rec)), .DEPTH(SOURCE_SLOTS)) u_src_ram (
        .i_clk   (i_clk),
        .i_we    (src_we),
        .i_waddr (src_waddr),
        .i_wdata (src_wdata),
        .i_raddr (src_raddr),
        .o_rdata (src_rdata)
    );

    sft_ram #(.WIDTH($bits(t_conn_rec)), .DEPTH(CONN_TOTAL)) u_conn_ram (
        .i_clk   (i_clk),
        .i_we    (conn_we),
        .i_waddr (conn_waddr),
        .i_wdata (conn_wdata),
        .i_raddr (conn_raddr),
        .o_rdata (conn_rdata)
    );

    assign srec = t_src_rec'(src_rdata);
    assign crec = t_conn_rec'(conn_rdata);

    assign busy     = (r_state != S_IDLE);
    assign o_done   = (r_state == S_DONE);
    assign o_result = r_res;
    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite;

    always_comb begin
        unique case (paddr[5:3])
            REG_WINDOW:   prdata = 64'(r_wl);
            REG_TIMEOUT:  prdata = 64'(r_hot);
            REG_HO_LIMIT: prdata = 64'(r_hol);
            REG_BURST:    prdata = 64'(r_sbl);
            REG_CAPACITY: prdata = 64'(r_cap);
            default:      prdata = '0;
        endcase
    end

    assign swap    = (r_phase == PH_CLOSE1);
    assign k_hi    = swap ? r_dhi : r_shi;
    assign k_lo    = swap ? r_dlo : r_slo;
    assign p_hi    = swap ? r_shi : r_dhi;
    assign p_lo    = swap ? r_slo : r_dlo;
    assign c_lp    = swap ? r_dp : r_sp;
    assign c_rp    = swap ? r_sp : r_dp;
    assign has_syn = r_fl[FLG_SYN] && !r_fl[FLG_ACK];

    assign pkt_ok = (i_item.operation == OP_PACKET) && i_item.valid_tcp &&
                    ((i_item.addr_family == FAM_V4) || (i_item.addr_family == FAM_V6));
    assign in_shi = (i_item.addr_family == FAM_V4) ? '0 : i_item.src_addr_hi;
    assign in_dhi = (i_item.addr_family == FAM_V4) ? '0 : i_item.dst_addr_hi;
    assign in_slo = (i_item.addr_family == FAM_V4) ? {32'd0, i_item.src_addr_lo[31:0]}
                                                    : i_item.src_addr_lo;
    assign in_dlo = (i_item.addr_family == FAM_V4) ? {32'd0, i_item.dst_addr_lo[31:0]}
                                                    : i_item.dst_addr_lo;

    assign cap_min = (CMW'(r_cap) < CMW'(SOURCE_SLOTS)) ? CMW'(r_cap) : CMW'(SOURCE_SLOTS);
    assign cap_eff = (cap_min == '0) ? CMW'(1) : cap_min;
    assign evict   = CMW'(r_cnt) >= cap_eff;
    assign m_ok    = r_found && !(evict && (r_m == r_vic));
    assign free_i  = (evict && (!r_ffree || (r_vic < r_free))) ? r_vic : r_free;

    assign conn_base = TAW'(TAW'(r_s[SAW-1:0]) * TAW'(CONNS_PER_SOURCE));
    assign conn_raddr = TAW'(conn_base + TAW'(r_c[CAW-1:0]));
    assign conn_waddr = TAW'(conn_base + TAW'(slot));
    assign conn_wdata = t_conn_rec'{hi: r_dhi, lo: r_dlo, fam: r_fam, lp: r_sp, rp: r_dp,
                                    tm: r_now};

    assign adv_phase = (r_phase == PH_CLOSE1) ? PH_CLOSE2 : PH_SYN;
    assign adv_state = ((r_phase == PH_CLOSE1) || has_syn) ? S_SINIT : S_DONE;

    always_comb begin
        slot      = r_cfound ? r_mc : (r_fifound ? r_fi : r_mi);
        counted   = r_rec.mask[slot] && !r_agem[slot];
        active    = counted ? r_keep : CCW'(r_keep + 1'b1);
        alert_now = !r_rec.alert &&
                    ((HCW'(active) >= HCW'(r_hol)) ||
                     ((r_rec.syn >= r_sbl) && (r_rec.comp == '0)));
        syw_rec            = r_rec;
        syw_rec.mask       = r_rec.mask & ~r_agem;
        syw_rec.mask[slot] = 1'b1;
        syw_rec.alert      = r_rec.alert | alert_now;

        clw_rec            = r_rec;
        clw_rec.mask[r_mc] = 1'b0;
        if (r_rec.comp != CNT_MAX) begin
            clw_rec.comp = r_rec.comp + 16'd1;
        end

        sww_rec      = r_rec;
        sww_rec.mask = r_rec.mask & ~r_agem;

        win_reset = (r_rec.ws == '0) || f_aged(r_now, r_rec.ws, 64'(r_wl));
        upd_rec   = r_rec;
        if (win_reset) begin
            upd_rec.ws    = r_now;
            upd_rec.syn   = '0;
            upd_rec.comp  = '0;
            upd_rec.alert = 1'b0;
        end
        upd_rec.ls = r_now;
        if (upd_rec.syn != CNT_MAX) begin
            upd_rec.syn = upd_rec.syn + 16'd1;
        end
    end

    always_comb begin
        n_state = r_state;   n_phase = r_phase;   n_valid = r_valid;
        n_fam = r_fam;   n_shi = r_shi;   n_slo = r_slo;   n_dhi = r_dhi;   n_dlo = r_dlo;
        n_sp = r_sp;     n_dp = r_dp;     n_fl = r_fl;     n_now = r_now;
        n_i = r_i;   n_cnt = r_cnt;   n_s = r_s;   n_pv = r_pv;   n_found = r_found;
        n_ffree = r_ffree;   n_vfound = r_vfound;   n_pi = r_pi;   n_m = r_m;
        n_free = r_free;     n_vic = r_vic;   n_vls = r_vls;   n_rec = r_rec;
        n_c = r_c;   n_keep = r_keep;   n_cpv = r_cpv;   n_cfound = r_cfound;
        n_fifound = r_fifound;   n_minf = r_minf;   n_pc = r_pc;   n_mc = r_mc;
        n_fi = r_fi;   n_mi = r_mi;   n_mt = r_mt;   n_agem = r_agem;   n_res = r_res;
        src_we    = 1'b0;
        src_waddr = r_s[SAW-1:0];
        src_wdata = r_rec;
        src_raddr = r_i[SAW-1:0];
        conn_we   = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_fam = i_item.addr_family;
                    n_shi = in_shi;   n_slo = in_slo;   n_dhi = in_dhi;   n_dlo = in_dlo;
                    n_sp  = i_item.src_port;   n_dp = i_item.dst_port;
                    n_fl  = i_item.tcp_flags;
                    n_now = TIME_BITS'(i_item.time_us);
                    n_res = '0;
                    n_s   = '0;
                    priority if (i_item.operation == OP_CLEAR) begin
                        n_valid = '0;
                        n_state = S_DONE;
                    end else if (i_item.operation == OP_SWEEP) begin
                        n_phase = PH_SWEEP;
                        n_state = S_SWRD;
                    end else if (pkt_ok && ((i_item.tcp_flags & FLG_CLOSE_MASK) != '0)) begin
                        n_phase = PH_CLOSE1;
                        n_state = S_SINIT;
                    end else if (pkt_ok && i_item.tcp_flags[FLG_SYN] &&
                                 !i_item.tcp_flags[FLG_ACK]) begin
                        n_phase = PH_SYN;
                        n_state = S_SINIT;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_SINIT: begin
                n_i = '0;   n_pv = 1'b0;   n_cnt = '0;
                n_found = 1'b0;   n_ffree = 1'b0;   n_vfound = 1'b0;
                n_state = S_SSCAN;
            end
            S_SSCAN: begin
                if (r_i < SCW'(SOURCE_SLOTS)) begin
                    n_i  = SCW'(r_i + 1'b1);
                    n_pv = 1'b1;
                    n_pi = r_i[SAW-1:0];
                end else begin
                    n_pv = 1'b0;
                end
                if (r_pv) begin
                    if (r_valid[r_pi]) begin
                        n_cnt = SCW'(r_cnt + 1'b1);
                        if (!r_vfound || (srec.ls < r_vls)) begin
                            n_vfound = 1'b1;
                            n_vic    = r_pi;
                            n_vls    = srec.ls;
                        end
                        if (!r_found && (srec.fam == r_fam) && (srec.khi == k_hi) &&
                            (srec.klo == k_lo)) begin
                            n_found = 1'b1;
                            n_m     = r_pi;
                            n_rec   = srec;
                        end
                    end else if (!r_ffree) begin
                        n_ffree = 1'b1;
                        n_free  = r_pi;
                    end
                    if (r_pi == SAW'(SOURCE_SLOTS - 1)) begin
                        n_state = S_SRES;
                    end
                end
            end
            S_SRES: begin
                if (r_phase == PH_SYN) begin
                    if (evict) begin
                        n_valid[r_vic] = 1'b0;
                    end
                    if (m_ok) begin
                        n_s = SCW'(r_m);
                    end else begin
                        n_s = SCW'(free_i);
                        n_valid[free_i] = 1'b1;
                        n_rec = t_src_rec'{khi: r_shi, klo: r_slo, fam: r_fam, ws: '0, ls: '0,
                                           syn: '0, comp: '0, alert: 1'b0, mask: '0};
                    end
                    n_state = S_SUPD;
                end else if (r_found) begin
                    n_s     = SCW'(r_m);
                    n_state = S_CINIT;
                end else begin
                    n_phase = adv_phase;
                    n_state = adv_state;
                end
            end
            S_SUPD: begin
                n_rec   = upd_rec;
                n_state = S_CINIT;
            end
            S_CINIT: begin
                n_c = '0;   n_cpv = 1'b0;   n_keep = '0;   n_cfound = 1'b0;
                n_fifound = 1'b0;   n_minf = 1'b0;   n_agem = '0;
                n_state = S_CSCAN;
            end
            S_CSCAN: begin
                if (r_c < CCW'(CONNS_PER_SOURCE)) begin
                    n_c   = CCW'(r_c + 1'b1);
                    n_cpv = 1'b1;
                    n_pc  = r_c[CAW-1:0];
                end else begin
                    n_cpv = 1'b0;
                end
                if (r_cpv) begin
                    if (r_rec.mask[r_pc]) begin
                        if (f_aged(r_now, crec.tm, 64'(r_hot))) begin
                            n_agem[r_pc] = 1'b1;
                        end else begin
                            n_keep = CCW'(r_keep + 1'b1);
                        end
                        if (!r_cfound && (crec.fam == r_fam) && (crec.hi == p_hi) &&
                            (crec.lo == p_lo) && (crec.lp == c_lp) && (crec.rp == c_rp)) begin
                            n_cfound = 1'b1;
                            n_mc     = r_pc;
                        end
                        if (!r_minf || (crec.tm < r_mt)) begin
                            n_minf = 1'b1;
                            n_mi   = r_pc;
                            n_mt   = crec.tm;
                        end
                    end else if (!r_fifound) begin
                        n_fifound = 1'b1;
                        n_fi      = r_pc;
                    end
                    if (r_pc == CAW'(CONNS_PER_SOURCE - 1)) begin
                        priority if (r_phase == PH_SYN) begin
                            n_state = S_SYWR;
                        end else if (r_phase == PH_SWEEP) begin
                            n_state = S_SWWR;
                        end else if (n_cfound) begin
                            n_state = S_CLWR;
                        end else begin
                            n_phase = adv_phase;
                            n_state = adv_state;
                        end
                    end
                end
            end
            S_CLWR: begin
                src_we    = 1'b1;
                src_wdata = clw_rec;
                n_phase   = adv_phase;
                n_state   = adv_state;
            end
            S_SYWR: begin
                src_we    = 1'b1;
                src_wdata = syw_rec;
                conn_we   = 1'b1;
                n_res     = t_out'{alert: alert_now, half_open_count: 5'(active),
                                   syn_count: r_rec.syn};
                n_state   = S_DONE;
            end
            S_SWRD: begin
                src_raddr = r_s[SAW-1:0];
                priority if (r_s == SCW'(SOURCE_SLOTS)) begin
                    n_state = S_DONE;
                end else if (!r_valid[r_s[SAW-1:0]]) begin
                    n_s = SCW'(r_s + 1'b1);
                end else begin
                    n_state = S_SWCHK;
                end
            end
            S_SWCHK: begin
                if (f_aged(r_now, srec.ls, 64'({r_hot, 1'b0}))) begin
                    n_valid[r_s[SAW-1:0]] = 1'b0;
                    n_s     = SCW'(r_s + 1'b1);
                    n_state = S_SWRD;
                end else begin
                    n_rec   = srec;
                    n_state = S_CINIT;
                end
            end
            S_SWWR: begin
                src_we    = 1'b1;
                src_wdata = sww_rec;
                n_s       = SCW'(r_s + 1'b1);
                n_state   = S_SWRD;
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_phase <= PH_SYN;
            r_valid <= '0;
            r_wl    <= RST_WINDOW;
            r_hot   <= RST_TIMEOUT;
            r_hol   <= RST_HO_LIMIT;
            r_sbl   <= RST_BURST;
            r_cap   <= RST_CAPACITY;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            r_valid <= n_valid;
            if (cfg_wr) begin
                unique case (paddr[5:3])
                    REG_WINDOW:   r_wl  <= pwdata[47:0];
                    REG_TIMEOUT:  r_hot <= pwdata[46:0];
                    REG_HO_LIMIT: r_hol <= pwdata[4:0];
                    REG_BURST:    r_sbl <= pwdata[15:0];
                    REG_CAPACITY: r_cap <= pwdata[6:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_fam <= n_fam;   r_shi <= n_shi;   r_slo <= n_slo;   r_dhi <= n_dhi;
        r_dlo <= n_dlo;   r_sp <= n_sp;     r_dp <= n_dp;     r_fl <= n_fl;
        r_now <= n_now;
        r_i <= n_i;   r_cnt <= n_cnt;   r_s <= n_s;   r_pv <= n_pv;   r_found <= n_found;
        r_ffree <= n_ffree;   r_vfound <= n_vfound;   r_pi <= n_pi;   r_m <= n_m;
        r_free <= n_free;     r_vic <= n_vic;   r_vls <= n_vls;   r_rec <= n_rec;
        r_c <= n_c;   r_keep <= n_keep;   r_cpv <= n_cpv;   r_cfound <= n_cfound;
        r_fifound <= n_fifound;   r_minf <= n_minf;   r_pc <= n_pc;   r_mc <= n_mc;
        r_fi <= n_fi;   r_mi <= n_mi;   r_mt <= n_mt;   r_agem <= n_agem;
        r_res <= n_res;
    end

endmodule
`default_nettype wire

// File: tb/tb_top.sv
`default_nettype none
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import sft_pkg::*;

    localparam int NSRC  = 64;
    localparam int NCONN = 16;
    localparam int WDOG  = 20000;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  start = 1'b0;
    t_in                   i_item = '0;
    logic                  busy;
    logic                  o_done;
    t_out                  o_result;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_AW-1:0]     paddr = '0;
    logic [APB_DW-1:0]     pwdata = '0;
    logic [APB_DW-1:0]     prdata;
    logic                  pready;

    syn_flood_tracker DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .i_item(i_item), .busy(busy),
        .o_done(o_done), .o_result(o_result), .psel(psel), .penable(penable),
        .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    logic [47:0] cfg_window;
    logic [46:0] cfg_timeout;
    logic [4:0]  cfg_ho_limit;
    logic [15:0] cfg_burst;
    logic [6:0]  cfg_capacity;

    bit          src_ok    [NSRC];
    logic [1:0]  src_fam   [NSRC];
    logic [63:0] src_hi    [NSRC];
    logic [63:0] src_lo    [NSRC];
    logic [47:0] win_start [NSRC];
    logic [47:0] seen_at   [NSRC];
    int          syn_cnt   [NSRC];
    int          done_cnt  [NSRC];
    bit          alerted   [NSRC];

    bit          conn_ok    [NSRC*NCONN];
    logic [1:0]  conn_fam   [NSRC*NCONN];
    logic [63:0] conn_hi    [NSRC*NCONN];
    logic [63:0] conn_lo    [NSRC*NCONN];
    logic [15:0] conn_lport [NSRC*NCONN];
    logic [15:0] conn_rport [NSRC*NCONN];
    logic [47:0] conn_at    [NSRC*NCONN];

    t_out        pending_results[$];
    bit          fixed_valid = 1'b0;
    t_out        fixed_res = '0;
    int          errors = 0;
    int          quiet_cycles = 0;
    int          burst_left = 0;

    function automatic bit is_stale(logic [63:0] now, logic [63:0] then, logic [63:0] lim);
        return now > then && now - then > lim;
    endfunction

    function automatic void forget_source(int s);
        src_ok[s] = 1'b0;
        for (int c = 0; c < NCONN; c++) conn_ok[s*NCONN+c] = 1'b0;
    endfunction

    function automatic int lookup_source(logic [1:0] f, logic [63:0] hi, logic [63:0] lo);
        for (int s = 0; s < NSRC; s++)
            if (src_ok[s] && src_fam[s] == f && src_hi[s] == hi && src_lo[s] == lo) return s;
        return -1;
    endfunction

    function automatic int lookup_conn(int s, logic [1:0] f, logic [63:0] hi, logic [63:0] lo,
                                       logic [15:0] lp, logic [15:0] rp);
        int i;
        for (int c = 0; c < NCONN; c++) begin
            i = s*NCONN + c;
            if (conn_ok[i] && conn_fam[i] == f && conn_hi[i] == hi && conn_lo[i] == lo &&
                conn_lport[i] == lp && conn_rport[i] == rp) return i;
        end
        return -1;
    endfunction

    function automatic void finish_handshake(logic [1:0] f, logic [63:0] shi, logic [63:0] slo,
                                             logic [63:0] phi, logic [63:0] plo,
                                             logic [15:0] lp, logic [15:0] rp);
        int s;
        int i;
        s = lookup_source(f, shi, slo);
        if (s < 0) return;
        i = lookup_conn(s, f, phi, plo, lp, rp);
        if (i < 0) return;
        conn_ok[i] = 1'b0;
        if (done_cnt[s] < 65535) done_cnt[s]++;
    endfunction

    function automatic void drop_stale_conns(int s, logic [47:0] now);
        for (int c = 0; c < NCONN; c++)
            if (conn_ok[s*NCONN+c] && is_stale(now, conn_at[s*NCONN+c], cfg_timeout))
                conn_ok[s*NCONN+c] = 1'b0;
    endfunction

    function automatic void clear_tracker();
        for (int s = 0; s < NSRC; s++) forget_source(s);
    endfunction

    function automatic t_out flood_verdict(t_in x);
        t_out r;
        logic [1:0]  f;
        logic [63:0] shi, slo, dhi, dlo;
        int s, slot, cap, cnt, victim, i, active;
        r = '0;
        f = x.addr_family;
        if (x.operation == OP_CLEAR) begin
            clear_tracker();
            return r;
        end
        if (x.operation == OP_SWEEP) begin
            for (s = 0; s < NSRC; s++) begin
                if (!src_ok[s]) continue;
                if (is_stale(x.time_us, seen_at[s], {cfg_timeout, 1'b0})) forget_source(s);
                else drop_stale_conns(s, x.time_us);
            end
            return r;
        end
        if (x.operation != OP_PACKET || !x.valid_tcp || (f != FAM_V4 && f != FAM_V6))
            return r;
        shi = x.src_addr_hi; slo = x.src_addr_lo;
        dhi = x.dst_addr_hi; dlo = x.dst_addr_lo;
        if (f == FAM_V4) begin
            shi = '0; dhi = '0;
            slo = {32'd0, slo[31:0]}; dlo = {32'd0, dlo[31:0]};
        end
        if ((x.tcp_flags & FLG_CLOSE_MASK) != 0) begin
            finish_handshake(f, dhi, dlo, shi, slo, x.dst_port, x.src_port);
            finish_handshake(f, shi, slo, dhi, dlo, x.src_port, x.dst_port);
        end
        if (!x.tcp_flags[FLG_SYN] || x.tcp_flags[FLG_ACK]) return r;

        cap = (cfg_capacity < NSRC) ? cfg_capacity : NSRC;
        cnt = 0; victim = -1;
        for (s = 0; s < NSRC; s++)
            if (src_ok[s]) begin
                cnt++;
                if (victim < 0 || seen_at[s] < seen_at[victim]) victim = s;
            end
        if (cnt >= cap && victim >= 0) forget_source(victim);

        s = lookup_source(f, shi, slo);
        if (s < 0) begin
            for (s = 0; s < NSRC && src_ok[s]; s++);
            forget_source(s);
            src_ok[s] = 1'b1; src_fam[s] = f; src_hi[s] = shi; src_lo[s] = slo;
            win_start[s] = '0; seen_at[s] = '0; syn_cnt[s] = 0; done_cnt[s] = 0;
            alerted[s] = 1'b0;
        end
        if (win_start[s] == 0 || is_stale(x.time_us, win_start[s], cfg_window)) begin
            win_start[s] = x.time_us; syn_cnt[s] = 0; done_cnt[s] = 0; alerted[s] = 1'b0;
        end
        seen_at[s] = x.time_us;
        if (syn_cnt[s] < 65535) syn_cnt[s]++;

        slot = lookup_conn(s, f, dhi, dlo, x.src_port, x.dst_port);
        if (slot < 0) begin
            for (int c = 0; c < NCONN; c++) begin
                i = s*NCONN + c;
                if (!conn_ok[i]) begin
                    slot = i;
                    break;
                end
                if (slot < 0 || conn_at[i] < conn_at[slot]) slot = i;
            end
            conn_ok[slot] = 1'b1; conn_fam[slot] = f; conn_hi[slot] = dhi; conn_lo[slot] = dlo;
            conn_lport[slot] = x.src_port; conn_rport[slot] = x.dst_port;
        end
        conn_at[slot] = x.time_us;
        drop_stale_conns(s, x.time_us);

        active = 0;
        for (int c = 0; c < NCONN; c++) if (conn_ok[s*NCONN+c]) active++;
        if (!alerted[s] && (active >= cfg_ho_limit ||
                            (syn_cnt[s] >= cfg_burst && done_cnt[s] == 0))) begin
            alerted[s] = 1'b1;
            r.alert = 1'b1;
        end
        r.half_open_count = active[4:0];
        r.syn_count = syn_cnt[s][15:0];
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_out want;
        t_out got;
        quiet_cycles <= quiet_cycles + 1;
        if (i_rst_n && start && !busy) begin
            quiet_cycles <= 0;
            want = flood_verdict(i_item);
            pending_results.push_back(fixed_valid ? fixed_res : want);
        end
        if (i_rst_n && o_done) begin
            quiet_cycles <= 0;
            got = o_result;
            if (pending_results.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result beat %p", got);
            end else begin
                want = pending_results.pop_front();
                if (got.alert !== want.alert || got.half_open_count !== want.half_open_count ||
                    got.syn_count !== want.syn_count) begin
                    errors++;
                    if (errors <= 10) $display("mismatch: expected %p, got %p", want, got);
                end
            end
        end
        if (quiet_cycles >= WDOG) begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    task automatic send(t_in x, bit fixed, t_out res);
        int g;
        i_item <= x;
        start <= 1'b1;
        fixed_valid <= fixed;
        fixed_res <= res;
        do @(negedge i_clk); while (busy);
        @(posedge i_clk);
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 12);
            g = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (g > 0) begin
                start <= 1'b0;
                repeat (g) @(posedge i_clk);
            end
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        fixed_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() > 0) @(posedge i_clk);
        do @(negedge i_clk); while (busy);
        @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [63:0] val);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= APB_AW'({idx, 3'b000}); pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            REG_WINDOW:   cfg_window = val[47:0];
            REG_TIMEOUT:  cfg_timeout = val[46:0];
            REG_HO_LIMIT: cfg_ho_limit = val[4:0];
            REG_BURST:    cfg_burst = val[15:0];
            REG_CAPACITY: cfg_capacity = val[6:0];
            default: ;
        endcase
    endtask

    task automatic configure(logic [47:0] w, logic [46:0] t, logic [4:0] h, logic [15:0] b,
                             logic [6:0] c);
        write_reg(REG_WINDOW, 64'(w));
        write_reg(REG_TIMEOUT, 64'(t));
        write_reg(REG_HO_LIMIT, 64'(h));
        write_reg(REG_BURST, 64'(b));
        write_reg(REG_CAPACITY, 64'(c));
        @(posedge i_clk);
    endtask

    function automatic t_in pkt(logic [47:0] tm, logic [1:0] f, logic [63:0] s, logic [63:0] d,
                                logic [15:0] sp, logic [15:0] dp, logic [3:0] fl);
        t_in x;
        x = '0;
        x.operation = OP_PACKET; x.time_us = tm; x.valid_tcp = 1'b1; x.addr_family = f;
        x.src_addr_lo = s; x.dst_addr_lo = d; x.src_port = sp; x.dst_port = dp; x.tcp_flags = fl;
        return x;
    endfunction

    typedef struct {
        t_in  x;
        bit   fixed;
        t_out res;
    } t_row;

    localparam logic [63:0] HA = 64'h0A00_0001, HB = 64'hC0A8_0101, HC = 64'h0000_0005;

    initial begin
        t_row        rows[$];
        t_in         x;
        t_out        z;
        logic [1:0]  pf[8];
        logic [63:0] phi[8], plo[8];
        logic [15:0] ports[4];
        logic [47:0] now;
        int          a, b, k;

        cfg_window = RST_WINDOW; cfg_timeout = RST_TIMEOUT; cfg_ho_limit = RST_HO_LIMIT;
        cfg_burst = RST_BURST; cfg_capacity = RST_CAPACITY;
        clear_tracker();
        z = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        x = pkt(48'd50, FAM_V4, HA, HB, 16'd1, 16'd80, 4'b0001);
        x.operation = 2'd3;                                   rows.push_back('{x, 1, z});
        x = pkt(48'd50, FAM_V4, HA, HB, 16'd1, 16'd80, 4'b0001);
        x.valid_tcp = 1'b0;                                   rows.push_back('{x, 1, z});
        x.valid_tcp = 1'b1; x.addr_family = 2'd0;             rows.push_back('{x, 1, z});
        x.addr_family = 2'd3;                                 rows.push_back('{x, 1, z});
        rows.push_back('{pkt(48'd100, FAM_V4, HA, HB, 16'd1, 16'd80, 4'b0001), 1, '{0, 1, 1}});
        rows.push_back('{pkt(48'd101, FAM_V4, HA, HB, 16'd2, 16'd80, 4'b0001), 1, '{0, 2, 2}});
        rows.push_back('{pkt(48'd102, FAM_V4, HB, HA, 16'd80, 16'd1, 4'b0011), 1, z});
        rows.push_back('{pkt(48'd103, FAM_V4, HA, HB, 16'd1, 16'd80, 4'b0010), 1, z});
        rows.push_back('{pkt(48'd104, FAM_V4, HA, HB, 16'd3, 16'd80, 4'b0001), 1, '{0, 2, 3}});
        rows.push_back('{pkt(48'd105, FAM_V4, HA, HB, 16'd2, 16'd80, 4'b0100), 1, z});
        rows.push_back('{pkt(48'd106, FAM_V4, HB, HA, 16'd80, 16'd3, 4'b1000), 1, z});
        rows.push_back('{pkt(48'd107, FAM_V4, HA, HB, 16'd4, 16'd80, 4'b1111), 0, z});
        x = pkt(48'hFFFF_FFFF_FFFF, FAM_V6, '1, '1, 16'hFFFF, 16'hFFFF, 4'b0001);
        x.src_addr_hi = '1; x.dst_addr_hi = '1;               rows.push_back('{x, 1, '{0, 1, 1}});
        x = pkt(48'd90, FAM_V4, {32'hFFFF_FFFF, HA[31:0]}, HB, 16'd1, 16'd80, 4'b0001);
        x.src_addr_hi = '1;                                   rows.push_back('{x, 0, z});
        rows.push_back('{pkt(48'd0, FAM_V4, HC, HB, 16'd0, 16'd0, 4'b0001), 1, '{0, 1, 1}});
        rows.push_back('{pkt(48'd0, FAM_V4, HC, HB, 16'd0, 16'd0, 4'b0001), 1, '{0, 1, 1}});
        x = '0; x.operation = OP_SWEEP; x.time_us = 48'd20_000_000;
        rows.push_back('{x, 1, z});
        rows.push_back('{pkt(48'd20_000_001, FAM_V4, HA, HB, 16'd9, 16'd80, 4'b0001), 1, '{0, 1, 1}});
        x = '0; x.operation = OP_CLEAR;                       rows.push_back('{x, 1, z});
        rows.push_back('{pkt(48'd5, FAM_V4, HA, HB, 16'd9, 16'd80, 4'b0001), 1, '{0, 1, 1}});
        foreach (rows[r]) send(rows[r].x, rows[r].fixed, rows[r].res);
        drain();

        now = 48'd1000;
        for (int ph = 0; ph < 7; ph++) begin
            case (ph)
                0: configure(48'd300, 47'd200, 5'd3, 16'd5, 7'd4);
                1: configure('1, '1, 5'd16, 16'hFFFF, 7'd64);
                2: configure(48'd1, 47'd1, 5'd0, 16'd0, 7'd1);
                3: configure(48'd1000, 47'd500, 5'd31, 16'd2, 7'd127);
                4: configure(48'd120, 47'd80, 5'd6, 16'd8, 7'd0);
                5: configure(48'd500, 47'd60, 5'd16, 16'd3, 7'd2);
                default: configure(RST_WINDOW, RST_TIMEOUT, RST_HO_LIMIT, RST_BURST,
                                   RST_CAPACITY);
            endcase
            for (int p = 0; p < 8; p++) begin
                pf[p] = ($urandom_range(0, 1) == 0) ? FAM_V4 : FAM_V6;
                phi[p] = {$urandom, $urandom};
                plo[p] = {$urandom, $urandom};
            end
            for (int p = 0; p < 4; p++) ports[p] = $urandom;
            for (int n = 0; n < 140; n++) begin
                k = $urandom_range(0, 99);
                if (k < 4) now = now - $urandom_range(0, 200);
                else if (k < 6) now = {$urandom, $urandom};
                else now = now + $urandom_range(0, 40);
                a = $urandom_range(0, 7);
                b = $urandom_range(0, 7);
                x = pkt(now, pf[a], plo[a], plo[b], ports[$urandom_range(0, 3)],
                        ports[$urandom_range(0, 3)], 4'b0001);
                x.src_addr_hi = phi[a];
                x.dst_addr_hi = phi[b];
                k = $urandom_range(0, 99);
                if (k < 55) begin
                end else if (k < 78) begin
                    x.tcp_flags = $urandom_range(2, 15);
                    if ($urandom_range(0, 1) == 0) begin
                        x.src_addr_hi = phi[b]; x.src_addr_lo = plo[b];
                        x.dst_addr_hi = phi[a]; x.dst_addr_lo = plo[a];
                    end
                end else if (k < 84) begin
                    x.operation = OP_SWEEP;
                end else if (k < 86) begin
                    x.operation = OP_CLEAR;
                end else begin
                    x = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                         $urandom, $urandom, $urandom, $urandom, $urandom};
                    if ($urandom_range(0, 1) == 0) x.operation = OP_PACKET;
                end
                send(x, 0, z);
            end
            drain();
        end

        repeat (50) @(posedge i_clk);
        if (errors == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end
endmodule
`default_nettype wire
